// ===== rtl/sks_pkg.sv =====
// ----------------------------------------------------------------------------
// sks_pkg
// Shared types and codes for the sorted key set: request and response words,
// operation and status codes, and the control word sent to the cell row.
// ----------------------------------------------------------------------------
`default_nettype none

package sks_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] key;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [5:0]  position;
    logic [6:0]  entries_held;
  } rsp_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_key_set_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_set_unit
// Sorted set of up to DEPTH unsigned 32-bit keys held in a row of compare
// and shift cells, with insert, remove and lookup.
//
//   channel | dir | payload       | handshake
//   req     | in  | sks_pkg::req_t | req_valid / req_ready
//   rsp     | out | sks_pkg::rsp_t | rsp_valid / rsp_ready
//
// Each word is accepted, compared in every cell, then the row is shifted and the
// result register loaded; no new word enters until that update step is done.
// req_ready is high only in idle; a waiting result does not block accept.
// A stalled rsp holds the update step until the result register frees.
// Reset (sync, active high) clears the state, the count and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_set_unit #(
  parameter int unsigned DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sks_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sks_pkg::rsp_t rsp
);
  import sks_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned PXW = (IW > 6) ? IW : 6;
  localparam int unsigned CXW = (CW > 7) ? CW : 7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  state_t      state;
  logic [1:0]  op;
  logic [31:0] probe;
  logic [CW-1:0] count;

  cell_ctl_t   ctl;
  logic [31:0] held_w [DEPTH];
  logic [DEPTH-1:0] lt_w;
  logic [DEPTH-1:0] eq_w;
  logic [DEPTH-1:0] bnd_w;
  logic [DEPTH-1:0] sel;

  logic          upd_go;
  logic          hit;
  logic          full;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] pos_out;
  logic [CW-1:0] count_next;
  status_t       status_next;
  logic [PXW-1:0] pos_x;
  logic [CXW-1:0] count_x;

  assign req_ready = (state == S_IDLE);
  assign upd_go    = (state == S_UPD) && (!rsp_valid || rsp_ready);
  assign hit       = |eq_w;
  assign full      = (count == CW'(DEPTH));
  assign sel       = hit ? eq_w : bnd_w;

  assign ctl.cmp = (state == S_CMP);
  assign ctl.ins = upd_go && (op == OP_INSERT) && !hit && !full;
  assign ctl.rem = upd_go && (op == OP_REMOVE) && hit;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [31:0] lk;
    logic [31:0] rk;
    logic        llt;
    if (i == 0) begin : g_first
      assign lk  = probe;
      assign llt = 1'b1;
    end else begin : g_mid
      assign lk  = held_w[i-1];
      assign llt = lt_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rk = held_w[i];
    end else begin : g_inner
      assign rk = held_w[i+1];
    end
    sks_cell #(
      .INDEX (i),
      .CW    (CW)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .count     (count),
      .probe     (probe),
      .left_key  (lk),
      .right_key (rk),
      .left_lt   (llt),
      .held      (held_w[i]),
      .lt        (lt_w[i]),
      .eq        (eq_w[i]),
      .bnd       (bnd_w[i])
    );
  end

  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (sel[i]) begin
        pos_idx = pos_idx | IW'(i);
      end
    end
  end

  always_comb begin
    count_next  = count;
    pos_out     = '0;
    status_next = ST_OK;
    if (op == OP_INSERT) begin
      if (hit) begin
        status_next = ST_PRESENT;
        pos_out     = pos_idx;
      end else if (full) begin
        status_next = ST_FULL;
      end else begin
        pos_out    = pos_idx;
        count_next = count + CW'(1);
      end
    end else if (hit) begin
      pos_out = pos_idx;
      if (op == OP_REMOVE) begin
        count_next = count - CW'(1);
      end
    end else begin
      status_next = ST_ABSENT;
    end
  end

  assign pos_x   = PXW'(pos_out);
  assign count_x = CXW'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.operation;
            probe <= req.key;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          state <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            count             <= count_next;
            rsp.status        <= status_next;
            rsp.position      <= pos_x[5:0];
            rsp.entries_held  <= count_x[6:0];
            rsp_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (rsp_valid && rsp_ready && !upd_go) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sks_cell.sv =====
// ----------------------------------------------------------------------------
// sks_cell
// One slot of the sorted row: holds a key, compares it with the probe, and
// shifts in from its left or right neighbor on insert or remove.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_cell #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CW    = 7
) (
  input  logic               clk,
  input  sks_pkg::cell_ctl_t ctl,
  input  logic [CW-1:0]      count,
  input  logic [31:0]        probe,
  input  logic [31:0]        left_key,
  input  logic [31:0]        right_key,
  input  logic               left_lt,
  output logic [31:0]        held,
  output logic               lt,
  output logic               eq,
  output logic               bnd
);
  import sks_pkg::*;

  logic occ;

  assign occ = count > CW'(INDEX);
  // first slot not below the probe: insert point
  assign bnd = !lt && left_lt;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occ && (held < probe);
      eq <= occ && (held == probe);
    end
    if (ctl.ins && !lt) begin
      held <= left_lt ? probe : left_key;
    end else if (ctl.rem && !lt) begin
      held <= right_key;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sks_checker.sv =====
// ----------------------------------------------------------------------------
// sks_checker
// Port-level checks for the sorted key set, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sks_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_ready,
  input logic          rsp_valid,
  input logic          rsp_ready,
  input sks_pkg::rsp_t rsp
);
  import sks_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("rsp word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req accepted while previous word in flight");

  a_miss_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_ABSENT || rsp.status == ST_FULL)
      |-> rsp.position == 6'd0)
    else $error("nonzero position on miss or full");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid && req_ready)
    else $error("reset did not clear output valid");

endmodule

bind sorted_key_set_unit sks_checker u_sks_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
